// ----- rtl/per_user_usage_table_with_limit_scan_unit_defines.svh -----
// Assertion macros for the per-user usage table.
`ifndef PER_USER_USAGE_TABLE_WITH_LIMIT_SCAN_UNIT_DEFINES_SVH
`define PER_USER_USAGE_TABLE_WITH_LIMIT_SCAN_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PUUT_AST_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PUUT_AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/puut_pkg.sv -----
// Shared types, codes and constants of the per-user usage table.
package puut_pkg;

  localparam int DEF_MAX_USERS   = 32;
  localparam int DEF_TABLE_SLOTS = 48;

  localparam int UID_W   = 16;
  localparam int PAGES_W = 24;
  localparam int ACC_W   = 32;
  localparam int PROCS_W = 16;
  localparam int BYTES_W = 48;
  localparam int PSIZE_W = 17;
  localparam int PUID_W  = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;
  localparam int WORD_W  = UID_W + ACC_W + PROCS_W;
  localparam int HASH_SHIFT = 24;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_SCAN  = 2'd2;

  localparam logic [1:0] KIND_ADD_DONE   = 2'd0;
  localparam logic [1:0] KIND_CLEAR_DONE = 2'd1;
  localparam logic [1:0] KIND_SCAN_HIT   = 2'd2;
  localparam logic [1:0] KIND_SCAN_DONE  = 2'd3;

  localparam logic [1:0] ST_NEW     = 2'd0;
  localparam logic [1:0] ST_UPDATED = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LOG_MEM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KILL_MEM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_PROC  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KILL_PROC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PSIZE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PUID_A    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PUID_B    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PUID_C    = 3'd7;

  localparam logic [BYTES_W-1:0] RST_LOG_MEM   = 48'd67108864;
  localparam logic [BYTES_W-1:0] RST_KILL_MEM  = 48'd134217728;
  localparam logic [PROCS_W-1:0] RST_LOG_PROC  = 16'd50;
  localparam logic [PROCS_W-1:0] RST_KILL_PROC = 16'd100;
  localparam logic [PSIZE_W-1:0] RST_PSIZE     = 17'd4096;
  localparam logic [PUID_W-1:0]  RST_PUID      = 17'd65536;

  typedef struct packed {
    logic       clear;
    logic       load;
    logic       hash;
    logic       home;
    logic       scan_init;
    logic       rd;
    logic       adv;
    logic       ins;
    logic       upd;
    logic       mul;
    logic       hit_chk;
    logic       emit_add;
    logic [1:0] add_status;
    logic       emit_done;
  } cmd_t;

  typedef struct packed {
    logic slot_valid;
    logic key_match;
    logic full;
    logic wrap;
    logic last_slot;
  } sts_t;

endpackage

// ----- rtl/puut_ctrl.sv -----
// Sequencer for clear, add-with-probe and scan items.
module puut_ctrl import puut_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] op,
  input  sts_t       sts,
  output cmd_t       cmd,
  output logic       busy
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_H1    = 4'd1;
  localparam logic [3:0] S_H2    = 4'd2;
  localparam logic [3:0] S_PRD   = 4'd3;
  localparam logic [3:0] S_PCHK  = 4'd4;
  localparam logic [3:0] S_SRD   = 4'd5;
  localparam logic [3:0] S_SMUL  = 4'd6;
  localparam logic [3:0] S_SCMP  = 4'd7;
  localparam logic [3:0] S_SDONE = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          priority if (op == OP_CLEAR) begin
            cmd.clear = 1'b1;
          end else if (op == OP_ADD) begin
            cmd.load = 1'b1;
            state_nxt = S_H1;
          end else if (op == OP_SCAN) begin
            cmd.scan_init = 1'b1;
            state_nxt = S_SRD;
          end else begin
            // An unused op is taken and ignored.
            state_nxt = S_IDLE;
          end
        end
      end
      S_H1: begin
        cmd.hash = 1'b1;
        state_nxt = S_H2;
      end
      S_H2: begin
        cmd.home = 1'b1;
        state_nxt = S_PRD;
      end
      S_PRD: begin
        cmd.rd = 1'b1;
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        state_nxt = S_IDLE;
        priority if (!sts.slot_valid) begin
          cmd.emit_add = 1'b1;
          if (sts.full) begin
            cmd.add_status = ST_DROPPED;
          end else begin
            cmd.ins = 1'b1;
            cmd.add_status = ST_NEW;
          end
        end else if (sts.key_match) begin
          cmd.upd = 1'b1;
          cmd.emit_add = 1'b1;
          cmd.add_status = ST_UPDATED;
        end else if (sts.wrap) begin
          cmd.emit_add = 1'b1;
          cmd.add_status = ST_DROPPED;
        end else begin
          cmd.adv = 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_SRD: begin
        priority if (sts.slot_valid) begin
          cmd.rd = 1'b1;
          state_nxt = S_SMUL;
        end else if (sts.last_slot) begin
          state_nxt = S_SDONE;
        end else begin
          cmd.adv = 1'b1;
        end
      end
      S_SMUL: begin
        cmd.mul = 1'b1;
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        cmd.hit_chk = 1'b1;
        if (sts.last_slot) begin
          state_nxt = S_SDONE;
        end else begin
          cmd.adv = 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_SDONE: begin
        cmd.emit_done = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/puut_dp.sv -----
// Table memory, hashing, accumulation, limit checks and result registers.
module puut_dp import puut_pkg::*; #(
  parameter int MAX_USERS   = DEF_MAX_USERS,
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [UID_W-1:0]      in_uid,
  input  logic [PAGES_W-1:0]    in_mem_pages,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  output logic [1:0]            out_kind,
  output logic [1:0]            out_add_status,
  output logic [UID_W-1:0]      out_hit_uid,
  output logic                  out_kill_flag,
  output logic [PROCS_W-1:0]    out_proc_count,
  output logic [BYTES_W-1:0]    out_mem_bytes,
  output logic                  out_last
);

  localparam int IDX_W   = $clog2(TABLE_SLOTS);
  localparam int CNT_W   = $clog2(MAX_USERS + 1);
  localparam int RECIP   = (2**HASH_SHIFT + TABLE_SLOTS - 1) / TABLE_SLOTS;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = UID_W + RECIP_W;

  // Configuration registers.
  logic [BYTES_W-1:0] log_mem_r, kill_mem_r;
  logic [PROCS_W-1:0] log_proc_r, kill_proc_r;
  logic [PSIZE_W-1:0] psize_r;
  logic [PUID_W-1:0]  puid_a_r, puid_b_r, puid_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_mem_r   <= RST_LOG_MEM;
      kill_mem_r  <= RST_KILL_MEM;
      log_proc_r  <= RST_LOG_PROC;
      kill_proc_r <= RST_KILL_PROC;
      psize_r     <= RST_PSIZE;
      puid_a_r    <= RST_PUID;
      puid_b_r    <= RST_PUID;
      puid_c_r    <= RST_PUID;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOG_MEM:   log_mem_r   <= cfg_wdata[BYTES_W-1:0];
        CFG_KILL_MEM:  kill_mem_r  <= cfg_wdata[BYTES_W-1:0];
        CFG_LOG_PROC:  log_proc_r  <= cfg_wdata[PROCS_W-1:0];
        CFG_KILL_PROC: kill_proc_r <= cfg_wdata[PROCS_W-1:0];
        CFG_PSIZE:     psize_r     <= cfg_wdata[PSIZE_W-1:0];
        CFG_PUID_A:    puid_a_r    <= cfg_wdata[PUID_W-1:0];
        CFG_PUID_B:    puid_b_r    <= cfg_wdata[PUID_W-1:0];
        CFG_PUID_C:    puid_c_r    <= cfg_wdata[PUID_W-1:0];
        default: ;
      endcase
    end
  end

  // Item payload and hashing: home slot is uid times a scaled reciprocal
  // of the table size, which gives the exact quotient for 16-bit ids.
  logic [UID_W-1:0]   uid_r;
  logic [PAGES_W-1:0] pages_r;
  logic [PROD_W-1:0]  prod_r;
  logic [UID_W-1:0]   quot;
  logic [UID_W-1:0]   rem;

  assign quot = UID_W'(prod_r >> HASH_SHIFT);
  assign rem  = UID_W'(uid_r - UID_W'(quot * UID_W'(TABLE_SLOTS)));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      uid_r   <= in_uid;
      pages_r <= in_mem_pages;
    end
    if (cmd.hash) begin
      prod_r <= PROD_W'(uid_r) * PROD_W'(RECIP);
    end
  end

  // Slot pointer and home slot.
  logic [IDX_W-1:0] idx_r, home_r, idx_inc;
  logic             last_slot;

  assign last_slot = (idx_r == IDX_W'(TABLE_SLOTS - 1));
  assign idx_inc   = last_slot ? '0 : IDX_W'(idx_r + 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.home) begin
      idx_r  <= IDX_W'(rem);
      home_r <= IDX_W'(rem);
    end else if (cmd.scan_init) begin
      idx_r <= '0;
    end else if (cmd.adv) begin
      idx_r <= idx_inc;
    end
  end

  // Slot memory: key, page total and process count in one word.
  logic [WORD_W-1:0]      mem [TABLE_SLOTS];
  logic [WORD_W-1:0]      rdata_r;
  logic [TABLE_SLOTS-1:0] valid_r;
  logic [CNT_W-1:0]       count_r;
  logic [UID_W-1:0]       rkey;
  logic [ACC_W-1:0]       rpages;
  logic [PROCS_W-1:0]     rprocs;
  logic [ACC_W:0]         pages_sum;
  logic [ACC_W-1:0]       pages_sat;
  logic [PROCS_W-1:0]     procs_sat;

  assign rkey      = rdata_r[WORD_W-1 -: UID_W];
  assign rpages    = rdata_r[PROCS_W +: ACC_W];
  assign rprocs    = rdata_r[PROCS_W-1:0];
  assign pages_sum = {1'b0, rpages} + (ACC_W+1)'(pages_r);
  assign pages_sat = pages_sum[ACC_W] ? '1 : pages_sum[ACC_W-1:0];
  assign procs_sat = (&rprocs) ? rprocs : PROCS_W'(rprocs + 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata_r <= mem[idx_r];
    end
    if (cmd.ins) begin
      mem[idx_r] <= {uid_r, ACC_W'(pages_r), PROCS_W'(1)};
    end else if (cmd.upd) begin
      mem[idx_r] <= {rkey, pages_sat, procs_sat};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (cmd.ins) begin
      valid_r[idx_r] <= 1'b1;
      count_r <= CNT_W'(count_r + 1'b1);
    end
  end

  assign sts.slot_valid = valid_r[idx_r];
  assign sts.key_match  = (rkey == uid_r);
  assign sts.full       = (count_r >= CNT_W'(MAX_USERS));
  assign sts.wrap       = (idx_inc == home_r);
  assign sts.last_slot  = last_slot;

  // Byte total and limit checks.
  logic [BYTES_W:0]   bytes_r;
  logic [BYTES_W-1:0] bytes_sat;
  logic               is_prot, is_log, is_kill;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      bytes_r <= (BYTES_W+1)'(rpages) * (BYTES_W+1)'(psize_r);
    end
  end

  assign bytes_sat = bytes_r[BYTES_W] ? '1 : bytes_r[BYTES_W-1:0];
  assign is_prot = ({1'b0, rkey} == puid_a_r) || ({1'b0, rkey} == puid_b_r) ||
                   ({1'b0, rkey} == puid_c_r);
  assign is_log  = (bytes_sat >= log_mem_r) || (rprocs >= log_proc_r);
  assign is_kill = (bytes_sat >= kill_mem_r) || (rprocs >= kill_proc_r);

  // Result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.clear || cmd.emit_add || cmd.emit_done ||
                   (cmd.hit_chk && is_log && !is_prot);
    end
  end

  always_ff @(posedge clk) begin
    out_add_status <= '0;
    out_hit_uid    <= '0;
    out_kill_flag  <= 1'b0;
    out_proc_count <= '0;
    out_mem_bytes  <= '0;
    out_last       <= 1'b1;
    out_kind       <= KIND_SCAN_DONE;
    priority if (cmd.clear) begin
      out_kind <= KIND_CLEAR_DONE;
    end else if (cmd.emit_add) begin
      out_kind       <= KIND_ADD_DONE;
      out_add_status <= cmd.add_status;
    end else if (cmd.hit_chk) begin
      out_kind       <= KIND_SCAN_HIT;
      out_hit_uid    <= rkey;
      out_kill_flag  <= is_kill;
      out_proc_count <= rprocs;
      out_mem_bytes  <= bytes_sat;
      out_last       <= 1'b0;
    end else begin
      out_kind <= KIND_SCAN_DONE;
    end
  end

endmodule

// ----- rtl/per_user_usage_table_with_limit_scan_unit.sv -----
// Top level of the per-user usage table with limit scan.
//
//  Channel  Handshake                  Payload
//  input    start / busy               in_op, in_uid, in_mem_pages
//  result   out_valid (one-cycle)      out_kind .. out_last
//  config   cfg_we                     cfg_index, cfg_wdata
//
// A clear taken while idle gives its result the cycle after; an unused op
// gives none. Add registers the item and hash product, sets the home slot,
// then probes slots through the registered read of the single-port slot
// memory. Scan skips empty slots, reads, multiplies and checks used ones.
// Reset is synchronous and empties the table at once; no results can stall.
`include "per_user_usage_table_with_limit_scan_unit_defines.svh"
module per_user_usage_table_with_limit_scan_unit import puut_pkg::*; #(
  parameter int MAX_USERS   = DEF_MAX_USERS,
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_op,
  input  logic [UID_W-1:0]      in_uid,
  input  logic [PAGES_W-1:0]    in_mem_pages,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  output logic [1:0]            out_kind,
  output logic [1:0]            out_add_status,
  output logic [UID_W-1:0]      out_hit_uid,
  output logic                  out_kill_flag,
  output logic [PROCS_W-1:0]    out_proc_count,
  output logic [BYTES_W-1:0]    out_mem_bytes,
  output logic                  out_last
);

  cmd_t cmd;
  sts_t sts;

  puut_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  puut_dp #(
    .MAX_USERS   (MAX_USERS),
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_uid         (in_uid),
    .in_mem_pages   (in_mem_pages),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_add_status (out_add_status),
    .out_hit_uid    (out_hit_uid),
    .out_kill_flag  (out_kill_flag),
    .out_proc_count (out_proc_count),
    .out_mem_bytes  (out_mem_bytes),
    .out_last       (out_last)
  );

  `PUUT_AST_NOW(a_hit_not_last, out_valid && out_kind == KIND_SCAN_HIT, !out_last)
  `PUUT_AST_NOW(a_other_last, out_valid && out_kind != KIND_SCAN_HIT, out_last)
  `PUUT_AST_NEXT(a_add_busy, start && !busy && in_op == OP_ADD, busy && !out_valid)

endmodule
